// ===== rtl/core/tet_pkg.sv =====
// ----------------------------------------------------------------------------
// tet_pkg
// Shared types and constants for the touch event tracker.
// ----------------------------------------------------------------------------
package tet_pkg;

    localparam int MAX_FINGERS_DEF = 5;
    localparam int MASK_W          = 5;
    localparam int CFG_W           = 16;
    localparam int CFG_IDX_W       = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SESSION_TIMEOUT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MOVE_TOLERANCE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_TAP_WINDOW = 2'd2;

    // configuration reset values
    localparam logic [CFG_W-1:0] SESSION_TIMEOUT_RST   = 16'd200;
    localparam logic [CFG_W-1:0] MOVE_TOLERANCE_RST    = 16'd5;
    localparam logic [CFG_W-1:0] DOUBLE_TAP_WINDOW_RST = 16'd100;

    // event codes
    localparam logic [1:0] EV_NONE = 2'd0;
    localparam logic [1:0] EV_UP   = 2'd1;
    localparam logic [1:0] EV_DOWN = 2'd2;
    localparam logic [1:0] EV_MOVE = 2'd3;

    typedef struct packed {
        logic        first_in_frame;
        logic [2:0]  finger_count;
        logic [2:0]  slot;
        logic [15:0] x_position;
        logic [15:0] y_position;
        logic [31:0] stamp_ms;
        logic [1:0]  reported_event;
    } point_req_t;

    typedef struct packed {
        logic [2:0]        out_slot;
        logic [1:0]        event_code;
        logic              filtered;
        logic [MASK_W-1:0] lifted_mask;
        logic              session_restart;
    } point_res_t;

    // frame context seen by the current request
    typedef struct packed {
        logic [2:0]        count;
        logic [2:0]        base_count;
        logic              fresh_session;
        logic [MASK_W-1:0] lifted_mask;
        logic              restart;
    } frame_view_t;

    // bits lo..hi-1 set, limited to the mask width
    function automatic logic [MASK_W-1:0] range_mask(logic [2:0] lo, logic [2:0] hi);
        logic [MASK_W-1:0] m;
        m = '0;
        for (int i = 0; i < MASK_W; i++) begin
            m[i] = (3'(i) >= lo) && (3'(i) < hi);
        end
        return m;
    endfunction

endpackage

// ===== rtl/core/tet_frame_ctl.sv =====
// ----------------------------------------------------------------------------
// tet_frame_ctl
// Frame start handling: session restart decision, lift mask, frame counts.
// ----------------------------------------------------------------------------
module tet_frame_ctl #(
    parameter int MAX_FINGERS = tet_pkg::MAX_FINGERS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      advance,
    input  logic                      first_in_frame,
    input  logic [2:0]                finger_count,
    input  logic [31:0]               stamp_ms,
    input  logic [tet_pkg::CFG_W-1:0] session_timeout,
    output tet_pkg::frame_view_t      view
);

    localparam logic [4:0] MAX_CNT = 5'(MAX_FINGERS);

    logic [2:0]  previous_count_reg, previous_count_next;
    logic [2:0]  base_count_reg, base_count_next;
    logic        fresh_session_reg, fresh_session_next;
    logic [31:0] last_frame_time_reg, last_frame_time_next;

    logic [2:0]  count_sat;
    logic [31:0] gap;
    logic        ns;

    always_comb begin
        count_sat = ({2'b0, finger_count} > MAX_CNT) ? MAX_CNT[2:0] : finger_count;
        gap       = stamp_ms - last_frame_time_reg;
        ns        = (count_sat != 3'd0) && (gap > {16'b0, session_timeout});

        if (first_in_frame) begin
            previous_count_next  = count_sat;
            base_count_next      = ns ? 3'd0 : previous_count_reg;
            fresh_session_next   = ns;
            last_frame_time_next = stamp_ms;
            view.lifted_mask     = tet_pkg::range_mask(ns ? 3'd0 : count_sat,
                                                       previous_count_reg);
            view.restart         = ns;
        end else begin
            previous_count_next  = previous_count_reg;
            base_count_next      = base_count_reg;
            fresh_session_next   = fresh_session_reg;
            last_frame_time_next = last_frame_time_reg;
            view.lifted_mask     = '0;
            view.restart         = 1'b0;
        end
        view.count         = previous_count_next;
        view.base_count    = base_count_next;
        view.fresh_session = fresh_session_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            previous_count_reg  <= 3'd0;
            base_count_reg      <= 3'd0;
            fresh_session_reg   <= 1'b0;
            last_frame_time_reg <= 32'd0;
        end else if (advance) begin
            previous_count_reg  <= previous_count_next;
            base_count_reg      <= base_count_next;
            fresh_session_reg   <= fresh_session_next;
            last_frame_time_reg <= last_frame_time_next;
        end
    end

endmodule

// ===== rtl/core/touch_event_tracker.sv =====
// ----------------------------------------------------------------------------
// touch_event_tracker
// Resolves touch points into down/move events, filters double taps and
// reports lifted slots at each frame start.
// ----------------------------------------------------------------------------
//  channel  | ports                          | carries
//  ---------+--------------------------------+-------------------------------
//  input    | s_valid s_ready s_data         | one touch point request
//  result   | m_valid m_ready m_data         | one resolved event per request
//  config   | cfg_we cfg_index cfg_wdata     | timeout, tolerance, tap window
//
//  One request per cycle while m_ready holds; requests pass the input register,
//  then the result register. Slot state is read and written in the cycle the
//  request leaves the input register. Reset clears all state and restores
//  register defaults. A stalled result holds the input register; while the
//  result waits, one more request is still taken into an empty input register.
// ----------------------------------------------------------------------------
module touch_event_tracker #(
    parameter int MAX_FINGERS = tet_pkg::MAX_FINGERS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  tet_pkg::point_req_t           s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output tet_pkg::point_res_t           m_data,
    input  logic                          cfg_we,
    input  logic [tet_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tet_pkg::CFG_W-1:0]     cfg_wdata
);

    localparam int         IDX_W   = (MAX_FINGERS > 1) ? $clog2(MAX_FINGERS) : 1;
    localparam logic [4:0] MAX_CNT = 5'(MAX_FINGERS);

    logic [tet_pkg::CFG_W-1:0] session_timeout_reg;
    logic [tet_pkg::CFG_W-1:0] move_tolerance_reg;
    logic [tet_pkg::CFG_W-1:0] double_tap_window_reg;

    tet_pkg::point_req_t in_reg;
    logic                in_valid_reg, in_valid_next;
    tet_pkg::point_res_t out_reg, out_next;
    logic                out_valid_reg, out_valid_next;

    logic [15:0] slot_x_reg   [MAX_FINGERS];
    logic [15:0] slot_y_reg   [MAX_FINGERS];
    logic [31:0] slot_tap_reg [MAX_FINGERS];

    tet_pkg::frame_view_t view;
    logic                 advance;
    logic [IDX_W-1:0]     idx;
    logic                 in_range;
    logic                 known;
    logic [15:0]          dx, dy, sx, sy;
    logic [31:0]          tap_gap;
    logic                 filt;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            session_timeout_reg   <= tet_pkg::SESSION_TIMEOUT_RST;
            move_tolerance_reg    <= tet_pkg::MOVE_TOLERANCE_RST;
            double_tap_window_reg <= tet_pkg::DOUBLE_TAP_WINDOW_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                tet_pkg::CFG_SESSION_TIMEOUT:   session_timeout_reg   <= cfg_wdata;
                tet_pkg::CFG_MOVE_TOLERANCE:    move_tolerance_reg    <= cfg_wdata;
                tet_pkg::CFG_DOUBLE_TAP_WINDOW: double_tap_window_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    tet_frame_ctl #(
        .MAX_FINGERS(MAX_FINGERS)
    ) u_frame_ctl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .advance        (advance),
        .first_in_frame (in_reg.first_in_frame),
        .finger_count   (in_reg.finger_count),
        .stamp_ms       (in_reg.stamp_ms),
        .session_timeout(session_timeout_reg),
        .view           (view)
    );

    always_comb begin
        idx      = IDX_W'(in_reg.slot);
        in_range = (in_reg.slot < view.count) && ({2'b0, in_reg.slot} < MAX_CNT);
        known    = (in_reg.slot < view.base_count) && !view.fresh_session;
        sx       = slot_x_reg[idx];
        sy       = slot_y_reg[idx];
        dx       = (in_reg.x_position >= sx) ? in_reg.x_position - sx
                                             : sx - in_reg.x_position;
        dy       = (in_reg.y_position >= sy) ? in_reg.y_position - sy
                                             : sy - in_reg.y_position;
        tap_gap  = in_reg.stamp_ms - slot_tap_reg[idx];
        filt     = known && (dx < move_tolerance_reg) && (dy < move_tolerance_reg)
                   && (tap_gap < {16'b0, double_tap_window_reg});

        out_next.out_slot        = in_reg.slot;
        out_next.lifted_mask     = view.lifted_mask;
        out_next.session_restart = view.restart;
        out_next.filtered        = in_range && filt;
        if (!in_range) begin
            out_next.event_code = tet_pkg::EV_NONE;
        end else if (filt) begin
            out_next.event_code = in_reg.reported_event;
        end else if (!known) begin
            out_next.event_code = tet_pkg::EV_DOWN;
        end else if ((dx != 16'd0) || (dy != 16'd0)) begin
            out_next.event_code = tet_pkg::EV_MOVE;
        end else begin
            out_next.event_code = in_reg.reported_event;
        end

        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end

        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
        if (advance) begin
            out_reg <= out_next;
        end
    end

    // per-slot position and tap time
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_FINGERS; i++) begin
                slot_x_reg[i]   <= 16'd0;
                slot_y_reg[i]   <= 16'd0;
                slot_tap_reg[i] <= 32'd0;
            end
        end else if (advance && in_range) begin
            slot_tap_reg[idx] <= in_reg.stamp_ms;
            if (!filt) begin
                slot_x_reg[idx] <= in_reg.x_position;
                slot_y_reg[idx] <= in_reg.y_position;
            end
        end
    end

    // a filtered point can never open a new session
    a_filt_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.filtered |-> !m_data.session_restart)
        else $error("filtered result carries a session restart");

    // input stage only refuses while it holds a request
    a_busy_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> in_valid_reg && out_valid_reg && !m_ready)
        else $error("input stalled without a pending request");

    // a request leaving the input stage shows up as a result next cycle
    a_advance_out: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_valid && (m_data.out_slot == $past(in_reg.slot)))
        else $error("advanced request missing from result register");

    // lift and restart flags only on the first request of a frame
    a_flags_first: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && !in_reg.first_in_frame |=> m_data.lifted_mask == '0
                                             && !m_data.session_restart)
        else $error("frame start flags on a later request");

endmodule
